// ----- src/shipbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package shipbp_pkg;

	localparam int NUM_SETS_DEF = 2048;
	localparam int NUM_WAYS_DEF = 16;
	localparam int REUSE_DEPTH = 2048;
	localparam int REUSE_AW = 11;
	localparam int SETIDX_W = 11;
	localparam int WAYIDX_W = 4;
	localparam int VMASK_W = 16;
	localparam int ADDR_W = 64;
	localparam int WIN_W = 8;
	localparam int RRPV_W = 2;
	localparam int CTR_W = 2;
	localparam int SIG_W = 6;

	localparam logic [WIN_W-1:0] THR_RESET = 8'd200;
	localparam logic [WIN_W-1:0] WIN_MAX = 8'hFF;
	localparam logic [ADDR_W-1:0] STRIDE_BYTES = 64'd64;
	localparam logic [RRPV_W-1:0] RRPV_HIT = 2'd0;
	localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd1;
	localparam logic [RRPV_W-1:0] RRPV_LONG = 2'd2;
	localparam logic [RRPV_W-1:0] RRPV_MAX = 2'd3;
	localparam logic [CTR_W-1:0] CTR_RESET = 2'd1;
	localparam logic [CTR_W-1:0] CTR_MID = 2'd2;
	localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
	localparam logic [3:0] REDUCE_STEPS = 4'd10;

	typedef enum logic {
		OP_VICTIM = 1'b0,
		OP_UPDATE = 1'b1
	} shipbp_op_t;

	typedef struct packed {
		shipbp_op_t opcode;
		logic [SETIDX_W-1:0] set_index;
		logic [WAYIDX_W-1:0] way_index;
		logic [VMASK_W-1:0] valid_mask;
		logic [ADDR_W-1:0] program_counter;
		logic [ADDR_W-1:0] phys_addr;
		logic was_hit;
	} shipbp_req_t;

	typedef struct packed {
		logic [WAYIDX_W-1:0] victim_way;
		logic bypass_fill;
	} shipbp_rsp_t;

	typedef struct packed {
		logic inv_found;
		logic [WAYIDX_W-1:0] inv_way;
		logic [WIN_W-1:0] win;
		logic [CTR_W-1:0] ctr;
	} shipbp_calc_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_CALC,
		ST_COMMIT
	} shipbp_state_t;

	function automatic logic [REUSE_AW-1:0] reuse_index(input logic [ADDR_W-1:0] pc);
		logic [SIG_W-1:0] sig;
		sig = pc[5:0] ^ pc[11:6] ^ pc[17:12];
		return {sig[5:1], 6'b0} | {5'b0, sig};
	endfunction

endpackage

`default_nettype wire

// ----- src/shipbp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shipbp_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

`default_nettype wire

// ----- src/shipbp_calc.sv -----
`timescale 1ns / 1ps
`default_nettype none

module shipbp_calc #(
	parameter int NUM_WAYS = shipbp_pkg::NUM_WAYS_DEF
) (
	input  wire shipbp_pkg::shipbp_req_t                 item,
	input  wire logic [2*NUM_WAYS-1:0]                   row,
	input  wire logic [shipbp_pkg::WIN_W-1:0]            win,
	input  wire logic [shipbp_pkg::ADDR_W-1:0]           last,
	input  wire logic [shipbp_pkg::CTR_W-1:0]            ctr,
	output shipbp_pkg::shipbp_calc_t                     res,
	output logic [2*NUM_WAYS-1:0]                        row_lift
);

	localparam int INV_N = (NUM_WAYS < shipbp_pkg::VMASK_W) ? NUM_WAYS : shipbp_pkg::VMASK_W;

	logic [shipbp_pkg::ADDR_W-1:0] delta;
	logic stride;
	logic has_max;
	logic has_hi;
	logic has_any;
	logic [shipbp_pkg::RRPV_W-1:0] top;
	logic [shipbp_pkg::RRPV_W-1:0] lift;

	always_comb begin
		delta = item.phys_addr - last;
		stride = (last != '0) && ((delta == shipbp_pkg::STRIDE_BYTES) ||
			(delta == ('0 - shipbp_pkg::STRIDE_BYTES)));

		res.win = win;
		if (stride) begin
			if (win != shipbp_pkg::WIN_MAX) begin
				res.win = win + 8'd1;
			end
		end else if (win != '0) begin
			res.win = win - 8'd1;
		end

		res.ctr = ctr;
		if (item.was_hit) begin
			if (ctr != shipbp_pkg::CTR_MAX) begin
				res.ctr = ctr + 2'd1;
			end
		end else if (ctr != '0) begin
			res.ctr = ctr - 2'd1;
		end

		res.inv_found = 1'b0;
		res.inv_way = '0;
		for (int w = INV_N - 1; w >= 0; w--) begin
			if (!item.valid_mask[w]) begin
				res.inv_found = 1'b1;
				res.inv_way = shipbp_pkg::WAYIDX_W'(w);
			end
		end

		has_max = 1'b0;
		has_hi = 1'b0;
		has_any = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			has_max = has_max | (row[2*w+1] & row[2*w]);
			has_hi = has_hi | row[2*w+1];
			has_any = has_any | row[2*w+1] | row[2*w];
		end
		if (has_max) begin
			top = shipbp_pkg::RRPV_MAX;
		end else if (has_hi) begin
			top = shipbp_pkg::RRPV_LONG;
		end else if (has_any) begin
			top = shipbp_pkg::RRPV_NEAR;
		end else begin
			top = shipbp_pkg::RRPV_HIT;
		end
		lift = shipbp_pkg::RRPV_MAX - top;
		for (int w = 0; w < NUM_WAYS; w++) begin
			row_lift[2*w +: 2] = row[2*w +: 2] + lift;
		end
	end

endmodule

`default_nettype wire

// ----- src/ship_rrip_stream_bypass_policy_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Replacement policy engine: SRRIP ageing with a PC-signature reuse predictor and a per-set
// stream detector that bypasses miss fills. Each request beat passes through accept, state
// read, compute and commit; when NUM_SETS is below 2048 the set index is first reduced
// modulo NUM_SETS in a reduce state between accept and state read. The per-set state memory
// and the reuse counter memory each have one read and one write port, and each request beat
// makes a single pass through them. The response is held in an output register, so the next
// request is taken while a response beat waits. After reset a clearing pass initialises
// both memories; requests stall during it, configuration writes are accepted throughout.
module ship_rrip_stream_bypass_policy_core #(
	parameter int NUM_SETS = shipbp_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = shipbp_pkg::NUM_WAYS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire shipbp_pkg::shipbp_req_t     req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output shipbp_pkg::shipbp_rsp_t          rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [shipbp_pkg::WIN_W-1:0] cfg_data
);

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int ROW_W = 2 * NUM_WAYS;
	localparam int WORD_W = shipbp_pkg::ADDR_W + shipbp_pkg::WIN_W + ROW_W;
	localparam int CLR_DEPTH = (NUM_SETS > shipbp_pkg::REUSE_DEPTH) ?
		NUM_SETS : shipbp_pkg::REUSE_DEPTH;
	localparam int CLR_W = $clog2(CLR_DEPTH);
	localparam bit REDUCE_EN = NUM_SETS < (2 ** shipbp_pkg::SETIDX_W);

	shipbp_pkg::shipbp_state_t state_q, state_d;
	logic [CLR_W-1:0] clr_q;
	logic [shipbp_pkg::SETIDX_W-1:0] red_q;
	logic [3:0] k_q;
	shipbp_pkg::shipbp_req_t item_q;
	logic [shipbp_pkg::WIN_W-1:0] thr_q;
	shipbp_pkg::shipbp_calc_t calc_q;
	logic [ROW_W-1:0] row_q;
	shipbp_pkg::shipbp_rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept;
	logic set_re;
	logic calc_en;
	logic commit_go;
	logic clearing;

	logic [31:0] red_sub;
	logic [SET_W-1:0] set_addr;
	logic [shipbp_pkg::REUSE_AW-1:0] ridx;
	logic [WORD_W-1:0] set_rd;
	logic [shipbp_pkg::CTR_W-1:0] ctr_rd;
	logic [ROW_W-1:0] rd_row;
	logic [shipbp_pkg::WIN_W-1:0] rd_win;
	logic [shipbp_pkg::ADDR_W-1:0] rd_last;
	shipbp_pkg::shipbp_calc_t calc_d;
	logic [ROW_W-1:0] row_lift;

	logic set_we;
	logic [SET_W-1:0] set_waddr;
	logic [WORD_W-1:0] set_wdata;
	logic reuse_we;
	logic [shipbp_pkg::REUSE_AW-1:0] reuse_waddr;
	logic [shipbp_pkg::CTR_W-1:0] reuse_wdata;
	logic bypass;
	logic [shipbp_pkg::RRPV_W-1:0] newr;
	logic [ROW_W-1:0] upd_row;
	logic [shipbp_pkg::WAYIDX_W-1:0] first_max;
	shipbp_pkg::shipbp_rsp_t rsp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shipbp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_stall = 1'b1;
		set_re = 1'b0;
		calc_en = 1'b0;
		commit_go = 1'b0;
		clearing = 1'b0;
		case (state_q)
			shipbp_pkg::ST_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
					state_d = shipbp_pkg::ST_IDLE;
				end
			end
			shipbp_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = REDUCE_EN ? shipbp_pkg::ST_REDUCE : shipbp_pkg::ST_READ;
				end
			end
			shipbp_pkg::ST_REDUCE: begin
				if (k_q == '0) begin
					state_d = shipbp_pkg::ST_READ;
				end
			end
			shipbp_pkg::ST_READ: begin
				set_re = 1'b1;
				state_d = shipbp_pkg::ST_CALC;
			end
			shipbp_pkg::ST_CALC: begin
				calc_en = 1'b1;
				state_d = shipbp_pkg::ST_COMMIT;
			end
			shipbp_pkg::ST_COMMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					commit_go = 1'b1;
					state_d = shipbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = shipbp_pkg::ST_CLEAR;
			end
		endcase
	end

	assign accept = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			thr_q <= shipbp_pkg::THR_RESET;
			rsp_valid_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (commit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				k_q <= shipbp_pkg::REDUCE_STEPS;
			end else if (state_q == shipbp_pkg::ST_REDUCE) begin
				k_q <= k_q - 4'd1;
			end
		end
	end

	assign red_sub = 32'(NUM_SETS) << k_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
			red_q <= req.set_index;
		end else if (state_q == shipbp_pkg::ST_REDUCE) begin
			if (32'(red_q) >= red_sub) begin
				red_q <= red_q - red_sub[shipbp_pkg::SETIDX_W-1:0];
			end
		end
		if (calc_en) begin
			calc_q <= calc_d;
			row_q <= row_lift;
		end
		if (commit_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign set_addr = SET_W'(red_q);
	assign ridx = shipbp_pkg::reuse_index(item_q.program_counter);

	assign rd_last = set_rd[WORD_W-1 -: shipbp_pkg::ADDR_W];
	assign rd_win = set_rd[ROW_W +: shipbp_pkg::WIN_W];
	assign rd_row = set_rd[ROW_W-1:0];

	shipbp_calc #(
		.NUM_WAYS(NUM_WAYS)
	) u_calc (
		.item(item_q),
		.row(rd_row),
		.win(rd_win),
		.last(rd_last),
		.ctr(ctr_rd),
		.res(calc_d),
		.row_lift(row_lift)
	);

	always_comb begin
		bypass = !item_q.was_hit && (calc_q.win > thr_q);
		if (item_q.was_hit) begin
			newr = shipbp_pkg::RRPV_HIT;
		end else if (bypass) begin
			newr = shipbp_pkg::RRPV_MAX;
		end else if (calc_q.ctr == shipbp_pkg::CTR_MAX) begin
			newr = shipbp_pkg::RRPV_HIT;
		end else if (calc_q.ctr == shipbp_pkg::CTR_MID) begin
			newr = shipbp_pkg::RRPV_NEAR;
		end else begin
			newr = shipbp_pkg::RRPV_LONG;
		end

		upd_row = rd_row;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (32'(item_q.way_index) == w) begin
				upd_row[2*w +: 2] = newr;
			end
		end

		first_max = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row_q[2*w +: 2] == shipbp_pkg::RRPV_MAX) begin
				first_max = shipbp_pkg::WAYIDX_W'(w);
			end
		end

		rsp_d = '0;
		if (item_q.opcode == shipbp_pkg::OP_VICTIM) begin
			rsp_d.victim_way = calc_q.inv_found ? calc_q.inv_way : first_max;
		end else begin
			rsp_d.bypass_fill = bypass;
		end

		if (clearing) begin
			set_we = 32'(clr_q) < 32'(NUM_SETS);
			set_waddr = clr_q[SET_W-1:0];
			set_wdata = {{shipbp_pkg::ADDR_W{1'b0}}, {shipbp_pkg::WIN_W{1'b0}},
				{NUM_WAYS{shipbp_pkg::RRPV_LONG}}};
			reuse_we = 1'b1;
			reuse_waddr = clr_q[shipbp_pkg::REUSE_AW-1:0];
			reuse_wdata = shipbp_pkg::CTR_RESET;
		end else begin
			set_waddr = set_addr;
			reuse_waddr = ridx;
			reuse_wdata = calc_q.ctr;
			if (item_q.opcode == shipbp_pkg::OP_VICTIM) begin
				set_we = commit_go && !calc_q.inv_found;
				set_wdata = {rd_last, rd_win, row_q};
				reuse_we = 1'b0;
			end else begin
				set_we = commit_go;
				set_wdata = {item_q.phys_addr, calc_q.win, upd_row};
				reuse_we = commit_go;
			end
		end
	end

	shipbp_ram #(
		.DEPTH(NUM_SETS),
		.WIDTH(WORD_W)
	) u_set_ram (
		.clk(clk),
		.we(set_we),
		.waddr(set_waddr),
		.wdata(set_wdata),
		.re(set_re),
		.raddr(set_addr),
		.rdata(set_rd)
	);

	shipbp_ram #(
		.DEPTH(shipbp_pkg::REUSE_DEPTH),
		.WIDTH(shipbp_pkg::CTR_W)
	) u_reuse_ram (
		.clk(clk),
		.we(reuse_we),
		.waddr(reuse_waddr),
		.wdata(reuse_wdata),
		.re(set_re),
		.raddr(ridx),
		.rdata(ctr_rd)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == shipbp_pkg::ST_READ || state_q == shipbp_pkg::ST_REDUCE))
		else $error("Accepted request beat did not start the sequencer.");

	a_commit_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit_go |=> rsp_valid_q)
		else $error("Commit did not present a response beat.");

	a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shipbp_pkg::ST_CLEAR) |-> !rsp_valid_q)
		else $error("Response beat presented during the clearing pass.");

	a_no_write_outside_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(reuse_we && !clearing) |-> (state_q == shipbp_pkg::ST_COMMIT))
		else $error("Reuse counter written outside commit.");
`endif

endmodule

`default_nettype wire
